/* rtl/eight_bit_cpu_alu_with_flags_core_defines.svh */
// Assertion macros for the 8-bit CPU ALU core.
// Included by the top level; needs nothing else.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define EBALU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define EBALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ebalu_pkg.sv */
// Operation codes, flag positions and pipeline stage payloads of the ALU core.
// Standalone; used by the request interface and the top level.
package ebalu_pkg;

    localparam int unsigned KIND_W = 5;

    localparam logic [KIND_W-1:0] K_ADD    = 5'd0;
    localparam logic [KIND_W-1:0] K_ADC    = 5'd1;
    localparam logic [KIND_W-1:0] K_SUB    = 5'd2;
    localparam logic [KIND_W-1:0] K_SBC    = 5'd3;
    localparam logic [KIND_W-1:0] K_AND    = 5'd4;
    localparam logic [KIND_W-1:0] K_XOR    = 5'd5;
    localparam logic [KIND_W-1:0] K_OR     = 5'd6;
    localparam logic [KIND_W-1:0] K_CP     = 5'd7;
    localparam logic [KIND_W-1:0] K_INC    = 5'd8;
    localparam logic [KIND_W-1:0] K_DEC    = 5'd9;
    localparam logic [KIND_W-1:0] K_RLC    = 5'd10;
    localparam logic [KIND_W-1:0] K_RL     = 5'd11;
    localparam logic [KIND_W-1:0] K_RRC    = 5'd12;
    localparam logic [KIND_W-1:0] K_RR     = 5'd13;
    localparam logic [KIND_W-1:0] K_SLA    = 5'd14;
    localparam logic [KIND_W-1:0] K_SRA    = 5'd15;
    localparam logic [KIND_W-1:0] K_SRL    = 5'd16;
    localparam logic [KIND_W-1:0] K_SWAP   = 5'd17;
    localparam logic [KIND_W-1:0] K_BIT    = 5'd18;
    localparam logic [KIND_W-1:0] K_RES    = 5'd19;
    localparam logic [KIND_W-1:0] K_SET    = 5'd20;
    localparam logic [KIND_W-1:0] K_DAA    = 5'd21;
    localparam logic [KIND_W-1:0] K_CPL    = 5'd22;
    localparam logic [KIND_W-1:0] K_CCF    = 5'd23;
    localparam logic [KIND_W-1:0] K_SCF    = 5'd24;
    localparam logic [KIND_W-1:0] K_ADD16  = 5'd25;
    localparam logic [KIND_W-1:0] K_ADD16S = 5'd26;

    // Flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

    typedef logic [KIND_W-1:0] t_kind;

    // Stage 1: captured request plus all adder outputs
    typedef struct packed {
        t_kind       kind;
        logic [15:0] a;
        logic [7:0]  b;
        logic [3:0]  f;
        logic [2:0]  bi;
        logic        cz;
        logic [8:0]  sum9;
        logic        h_add;
        logic [8:0]  diff9;
        logic        h_sub;
        logic [15:0] sum16;
        logic        c16;
        logic        h16;
        logic [15:0] sums16;
        logic        c_s;
        logic        h_s;
    } t_s1;

    // Stage 2: selected result, flags except Z, and how to form Z
    typedef struct packed {
        logic [15:0] res;
        logic [7:0]  zsrc;
        logic        zcalc;
        logic        zfix;
        logic        n;
        logic        h;
        logic        c;
    } t_s2;

endpackage

/* rtl/ebalu_if.sv */
// Request and response channel interfaces of the ALU core.
// The request interface depends on ebalu_pkg for the operation code type.
interface ebalu_req_if;
    logic               valid;
    logic               ready;
    ebalu_pkg::t_kind   kind;
    logic [15:0]        operand_a;
    logic [15:0]        operand_b;
    logic [3:0]         flags_in;
    logic [2:0]         bit_index;
    logic               clear_zero;

    modport source (
        output valid, kind, operand_a, operand_b, flags_in, bit_index, clear_zero,
        input  ready
    );
    modport sink (
        input  valid, kind, operand_a, operand_b, flags_in, bit_index, clear_zero,
        output ready
    );
endinterface

interface ebalu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [3:0]  flags_out;

    modport source (
        output valid, result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result, flags_out,
        output ready
    );
endinterface

/* rtl/eight_bit_cpu_alu_with_flags_core.sv */
// 8-bit CPU ALU with Z/N/H/C flags: three-stage pipelined top level.
// Depends on ebalu_pkg, ebalu_if.sv and eight_bit_cpu_alu_with_flags_core_defines.svh.
//
// Usage:
//   i_req carries one request: kind, operand_a, operand_b, flags_in,
//   bit_index and clear_zero. It is taken at a clock edge where valid and
//   ready are both high. o_rsp carries the result and flags_out of each
//   request, in request order, one response per request.
//   Each request passes through three register stages (adders, result
//   select, zero detect) before its response shows on o_rsp. Throughput:
//   one request per cycle while o_rsp.ready is high, each stage taking a
//   new request every clock unless the stall below holds it.
//   Stall: when o_rsp.ready is low the output register holds; earlier
//   stages keep moving until they fill, so empty stages close up and
//   i_req.ready drops only when all three stages hold a request.
//   Reset (i_rst_n low at a clock edge) drops every request in flight;
//   i_req.ready is high again in the first cycle after reset.
`include "eight_bit_cpu_alu_with_flags_core_defines.svh"

module eight_bit_cpu_alu_with_flags_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ebalu_req_if.sink           i_req,
    ebalu_rsp_if.source         o_rsp
);

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when it is empty or the
    // next stage advances.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || o_rsp.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_req.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_req.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the request and run every adder in parallel.
    // ------------------------------------------------------------------
    ebalu_pkg::t_s1 n_s1, r_s1;

    logic [7:0]  a8_in, b8_in;
    logic        c_add, c_sub;
    logic [4:0]  nib_add, nib_sub, nib_s;
    logic [16:0] add16_full;
    logic [12:0] add12;
    logic [8:0]  add_lo;

    always_comb begin
        a8_in = i_req.operand_a[7:0];
        b8_in = i_req.operand_b[7:0];
        // carry in only for the with-carry forms
        c_add = (i_req.kind == ebalu_pkg::K_ADC) ? i_req.flags_in[ebalu_pkg::FLAG_C] : 1'b0;
        c_sub = (i_req.kind == ebalu_pkg::K_SBC) ? i_req.flags_in[ebalu_pkg::FLAG_C] : 1'b0;

        nib_add = 5'(i_req.operand_a[3:0]) + 5'(i_req.operand_b[3:0]) + 5'(c_add);
        nib_sub = 5'(i_req.operand_a[3:0]) - 5'(i_req.operand_b[3:0]) - 5'(c_sub);
        nib_s   = 5'(i_req.operand_a[3:0]) + 5'(i_req.operand_b[3:0]);
        add16_full = 17'(i_req.operand_a) + 17'(i_req.operand_b);
        add12   = 13'(i_req.operand_a[11:0]) + 13'(i_req.operand_b[11:0]);
        add_lo  = 9'(a8_in) + 9'(b8_in);

        n_s1.kind   = i_req.kind;
        n_s1.a      = i_req.operand_a;
        n_s1.b      = b8_in;
        n_s1.f      = i_req.flags_in;
        n_s1.bi     = i_req.bit_index;
        n_s1.cz     = i_req.clear_zero;
        n_s1.sum9   = 9'(a8_in) + 9'(b8_in) + 9'(c_add);
        n_s1.h_add  = nib_add[4];
        // borrow shows as bit 8 of the 9-bit difference
        n_s1.diff9  = 9'(a8_in) - 9'(b8_in) - 9'(c_sub);
        n_s1.h_sub  = nib_sub[4];
        n_s1.sum16  = add16_full[15:0];
        n_s1.c16    = add16_full[16];
        n_s1.h16    = add12[12];
        // signed offset add: flags from the unsigned low byte add
        n_s1.sums16 = i_req.operand_a + {{8{b8_in[7]}}, b8_in};
        n_s1.c_s    = add_lo[8];
        n_s1.h_s    = nib_s[4];
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the result and the N/H/C flags per operation, and
    // decide how Z is formed.
    // ------------------------------------------------------------------
    ebalu_pkg::t_s2 n_s2, r_s2;

    logic [7:0] a8, lv, v8, sh, mask, daa;
    logic       fz, fn, fh, fc, co, daa_hi, daa_lo;

    always_comb begin
        a8   = r_s1.a[7:0];
        fz   = r_s1.f[ebalu_pkg::FLAG_Z];
        fn   = r_s1.f[ebalu_pkg::FLAG_N];
        fh   = r_s1.f[ebalu_pkg::FLAG_H];
        fc   = r_s1.f[ebalu_pkg::FLAG_C];
        mask = 8'h01 << r_s1.bi;
        lv   = 8'h00;
        v8   = 8'h00;
        sh   = 8'h00;
        co   = 1'b0;

        // decimal adjust
        daa_hi = fc || (a8 > ebalu_pkg::DAA_HI_MAX);
        daa_lo = fh || (a8[3:0] > ebalu_pkg::DAA_LO_MAX);
        if (!fn) begin
            daa = a8 + (daa_hi ? ebalu_pkg::DAA_HI_ADJ : 8'h00)
                     + (daa_lo ? ebalu_pkg::DAA_LO_ADJ : 8'h00);
        end else begin
            daa = a8 - (fc ? ebalu_pkg::DAA_HI_ADJ : 8'h00)
                     - (fh ? ebalu_pkg::DAA_LO_ADJ : 8'h00);
        end

        // defaults: pass operand_a and keep every flag
        n_s2.res   = r_s1.a;
        n_s2.zsrc  = a8;
        n_s2.zcalc = 1'b0;
        n_s2.zfix  = fz;
        n_s2.n     = fn;
        n_s2.h     = fh;
        n_s2.c     = fc;

        case (r_s1.kind)
            ebalu_pkg::K_ADD, ebalu_pkg::K_ADC: begin
                n_s2.res   = {8'h00, r_s1.sum9[7:0]};
                n_s2.zsrc  = r_s1.sum9[7:0];
                n_s2.zcalc = 1'b1;
                n_s2.n     = 1'b0;
                n_s2.h     = r_s1.h_add;
                n_s2.c     = r_s1.sum9[8];
            end
            ebalu_pkg::K_SUB, ebalu_pkg::K_SBC, ebalu_pkg::K_CP: begin
                n_s2.res   = (r_s1.kind == ebalu_pkg::K_CP) ? r_s1.a
                                                            : {8'h00, r_s1.diff9[7:0]};
                n_s2.zsrc  = r_s1.diff9[7:0];
                n_s2.zcalc = 1'b1;
                n_s2.n     = 1'b1;
                n_s2.h     = r_s1.h_sub;
                n_s2.c     = r_s1.diff9[8];
            end
            ebalu_pkg::K_AND, ebalu_pkg::K_XOR, ebalu_pkg::K_OR: begin
                if (r_s1.kind == ebalu_pkg::K_AND) begin
                    lv = a8 & r_s1.b;
                end else if (r_s1.kind == ebalu_pkg::K_XOR) begin
                    lv = a8 ^ r_s1.b;
                end else begin
                    lv = a8 | r_s1.b;
                end
                n_s2.res   = {8'h00, lv};
                n_s2.zsrc  = lv;
                n_s2.zcalc = 1'b1;
                n_s2.n     = 1'b0;
                n_s2.h     = (r_s1.kind == ebalu_pkg::K_AND);
                n_s2.c     = 1'b0;
            end
            ebalu_pkg::K_INC: begin
                v8         = a8 + 8'h01;
                n_s2.res   = {8'h00, v8};
                n_s2.zsrc  = v8;
                n_s2.zcalc = 1'b1;
                n_s2.n     = 1'b0;
                n_s2.h     = (a8[3:0] == 4'hF);
            end
            ebalu_pkg::K_DEC: begin
                v8         = a8 - 8'h01;
                n_s2.res   = {8'h00, v8};
                n_s2.zsrc  = v8;
                n_s2.zcalc = 1'b1;
                n_s2.n     = 1'b1;
                n_s2.h     = (a8[3:0] == 4'h0);
            end
            ebalu_pkg::K_RLC, ebalu_pkg::K_RL, ebalu_pkg::K_RRC, ebalu_pkg::K_RR,
            ebalu_pkg::K_SLA, ebalu_pkg::K_SRA, ebalu_pkg::K_SRL: begin
                case (r_s1.kind)
                    ebalu_pkg::K_RLC: begin sh = {a8[6:0], a8[7]}; co = a8[7]; end
                    ebalu_pkg::K_RL:  begin sh = {a8[6:0], fc};    co = a8[7]; end
                    ebalu_pkg::K_RRC: begin sh = {a8[0], a8[7:1]}; co = a8[0]; end
                    ebalu_pkg::K_RR:  begin sh = {fc, a8[7:1]};    co = a8[0]; end
                    ebalu_pkg::K_SLA: begin sh = {a8[6:0], 1'b0};  co = a8[7]; end
                    ebalu_pkg::K_SRA: begin sh = {a8[7], a8[7:1]}; co = a8[0]; end
                    default:          begin sh = {1'b0, a8[7:1]};  co = a8[0]; end
                endcase
                n_s2.res  = {8'h00, sh};
                n_s2.zsrc = sh;
                // accumulator rotate forms may force Z clear
                n_s2.zcalc = !(r_s1.cz && (r_s1.kind == ebalu_pkg::K_RLC ||
                                           r_s1.kind == ebalu_pkg::K_RL  ||
                                           r_s1.kind == ebalu_pkg::K_RRC ||
                                           r_s1.kind == ebalu_pkg::K_RR));
                n_s2.zfix = 1'b0;
                n_s2.n    = 1'b0;
                n_s2.h    = 1'b0;
                n_s2.c    = co;
            end
            ebalu_pkg::K_SWAP: begin
                n_s2.res   = {8'h00, a8[3:0], a8[7:4]};
                n_s2.zsrc  = a8;
                n_s2.zcalc = 1'b1;
                n_s2.n     = 1'b0;
                n_s2.h     = 1'b0;
                n_s2.c     = 1'b0;
            end
            ebalu_pkg::K_BIT: begin
                n_s2.zfix = !a8[r_s1.bi];
                n_s2.n    = 1'b0;
                n_s2.h    = 1'b1;
            end
            ebalu_pkg::K_RES: begin
                n_s2.res = {8'h00, a8 & ~mask};
            end
            ebalu_pkg::K_SET: begin
                n_s2.res = {8'h00, a8 | mask};
            end
            ebalu_pkg::K_DAA: begin
                n_s2.res   = {8'h00, daa};
                n_s2.zsrc  = daa;
                n_s2.zcalc = 1'b1;
                n_s2.h     = 1'b0;
                n_s2.c     = fn ? fc : daa_hi;
            end
            ebalu_pkg::K_CPL: begin
                n_s2.res = {8'h00, ~a8};
                n_s2.n   = 1'b1;
                n_s2.h   = 1'b1;
            end
            ebalu_pkg::K_CCF: begin
                n_s2.n = 1'b0;
                n_s2.h = 1'b0;
                n_s2.c = !fc;
            end
            ebalu_pkg::K_SCF: begin
                n_s2.n = 1'b0;
                n_s2.h = 1'b0;
                n_s2.c = 1'b1;
            end
            ebalu_pkg::K_ADD16: begin
                n_s2.res = r_s1.sum16;
                n_s2.n   = 1'b0;
                n_s2.h   = r_s1.h16;
                n_s2.c   = r_s1.c16;
            end
            ebalu_pkg::K_ADD16S: begin
                n_s2.res  = r_s1.sums16;
                n_s2.zfix = 1'b0;
                n_s2.n    = 1'b0;
                n_s2.h    = r_s1.h_s;
                n_s2.c    = r_s1.c_s;
            end
            default: begin
                // unused codes pass operand_a and the flags unchanged
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2 <= n_s2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: zero detect and flag assembly into the output register.
    // ------------------------------------------------------------------
    logic [15:0] r_res;
    logic [3:0]  r_flags;
    logic [3:0]  n_flags;

    always_comb begin
        n_flags = 4'h0;
        n_flags[ebalu_pkg::FLAG_Z] = r_s2.zcalc ? (r_s2.zsrc == 8'h00) : r_s2.zfix;
        n_flags[ebalu_pkg::FLAG_N] = r_s2.n;
        n_flags[ebalu_pkg::FLAG_H] = r_s2.h;
        n_flags[ebalu_pkg::FLAG_C] = r_s2.c;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_res   <= r_s2.res;
            r_flags <= n_flags;
        end
    end

    assign o_rsp.valid     = r_v3;
    assign o_rsp.result    = r_res;
    assign o_rsp.flags_out = r_flags;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `EBALU_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n,
        i_req.valid && i_req.ready, r_v1, "accepted request did not reach stage 1")
    `EBALU_ASSERT_IMPL(a_empty_s1_ready, i_clk, i_rst_n,
        !r_v1, i_req.ready, "request refused while stage 1 is empty")
    `EBALU_ASSERT_NEXT(a_s2_holds, i_clk, i_rst_n,
        r_v2 && !en2, r_v2 && $stable(r_s2), "stalled stage 2 lost or changed its request")

endmodule

/* sim/tb_eight_bit_cpu_alu_with_flags_core.sv */
// Self-checking testbench for the 8-bit CPU ALU core with Z/N/H/C flags.
// Needs ebalu_pkg, the ebalu_req_if/ebalu_rsp_if interfaces and the core's top level.
// Predicts each response from the request and checks the responses in order.
module tb_eight_bit_cpu_alu_with_flags_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_RANDOM    = 2000;
    localparam int unsigned DRAIN_WAIT  = 12;      // settling wait after the last response is checked
    localparam int unsigned CYCLE_LIMIT = 200000;  // slowest legal run is far below this

    // One ALU request as it travels on i_req.
    typedef struct packed {
        ebalu_pkg::t_kind kind;
        logic [15:0]      operand_a;
        logic [15:0]      operand_b;
        logic [3:0]       flags_in;
        logic [2:0]       bit_index;
        logic             clear_zero;
    } t_alu_req;

    // One ALU response as it travels on o_rsp.
    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } t_alu_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    ebalu_req_if req_if ();
    ebalu_rsp_if rsp_if ();

    eight_bit_cpu_alu_with_flags_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    t_alu_req    pending_ops[$];     // requests waiting to be offered
    t_alu_rsp    expected_alu[$];    // predicted responses, oldest first
    t_alu_req    offered_op;         // request currently held on i_req
    int unsigned n_taken = 0;        // requests accepted so far
    int unsigned n_errors = 0;
    int unsigned cycle_cnt = 0;

    // ------------------------------------------------------------------
    // Predictor: compute result and new flags of one request.
    // ------------------------------------------------------------------
    function automatic t_alu_rsp predict_alu(t_alu_req q);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [12:0] s13;
        logic [16:0] s17;
        logic        cin;
        logic        cy;
        logic        acc_rotate;
        logic [3:0]  f;
        t_alu_rsp    p;
        a   = q.operand_a[7:0];
        b   = q.operand_b[7:0];
        cin = q.flags_in[ebalu_pkg::FLAG_C];
        f   = '0;
        r8  = a;
        p.result    = q.operand_a;
        p.flags_out = q.flags_in;
        case (q.kind)
            ebalu_pkg::K_ADD, ebalu_pkg::K_ADC: begin
                cy  = (q.kind == ebalu_pkg::K_ADC) & cin;
                s9  = {1'b0, a} + {1'b0, b} + {8'd0, cy};
                s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
                f[ebalu_pkg::FLAG_C] = s9[8];
                f[ebalu_pkg::FLAG_H] = s5[4];
                f[ebalu_pkg::FLAG_Z] = (s9[7:0] == 8'h00);
                p.result    = {8'h00, s9[7:0]};
                p.flags_out = f;
            end
            ebalu_pkg::K_SUB, ebalu_pkg::K_SBC, ebalu_pkg::K_CP: begin
                // A negative difference shows up as the top bit of the wider field.
                cy  = (q.kind == ebalu_pkg::K_SBC) & cin;
                s9  = {1'b0, a} - {1'b0, b} - {8'd0, cy};
                s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
                f[ebalu_pkg::FLAG_N] = 1'b1;
                f[ebalu_pkg::FLAG_C] = s9[8];
                f[ebalu_pkg::FLAG_H] = s5[4];
                f[ebalu_pkg::FLAG_Z] = (s9[7:0] == 8'h00);
                if (q.kind != ebalu_pkg::K_CP) begin
                    p.result = {8'h00, s9[7:0]};
                end
                p.flags_out = f;
            end
            ebalu_pkg::K_AND, ebalu_pkg::K_XOR, ebalu_pkg::K_OR: begin
                r8 = (q.kind == ebalu_pkg::K_AND) ? (a & b)
                   : (q.kind == ebalu_pkg::K_XOR) ? (a ^ b) : (a | b);
                f[ebalu_pkg::FLAG_H] = (q.kind == ebalu_pkg::K_AND);
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00);
                p.result    = {8'h00, r8};
                p.flags_out = f;
            end
            ebalu_pkg::K_INC: begin
                r8 = a + 8'd1;
                f[ebalu_pkg::FLAG_C] = cin;
                f[ebalu_pkg::FLAG_H] = (a[3:0] == 4'hF);
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00);
                p.result    = {8'h00, r8};
                p.flags_out = f;
            end
            ebalu_pkg::K_DEC: begin
                r8 = a - 8'd1;
                f[ebalu_pkg::FLAG_N] = 1'b1;
                f[ebalu_pkg::FLAG_C] = cin;
                f[ebalu_pkg::FLAG_H] = (r8[3:0] == 4'hF);
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00);
                p.result    = {8'h00, r8};
                p.flags_out = f;
            end
            ebalu_pkg::K_RLC, ebalu_pkg::K_RL, ebalu_pkg::K_RRC, ebalu_pkg::K_RR,
            ebalu_pkg::K_SLA, ebalu_pkg::K_SRA, ebalu_pkg::K_SRL: begin
                case (q.kind)
                    ebalu_pkg::K_RLC: begin cy = a[7]; r8 = {a[6:0], a[7]}; end
                    ebalu_pkg::K_RL:  begin cy = a[7]; r8 = {a[6:0], cin}; end
                    ebalu_pkg::K_SLA: begin cy = a[7]; r8 = {a[6:0], 1'b0}; end
                    ebalu_pkg::K_RRC: begin cy = a[0]; r8 = {a[0], a[7:1]}; end
                    ebalu_pkg::K_RR:  begin cy = a[0]; r8 = {cin, a[7:1]}; end
                    ebalu_pkg::K_SRA: begin cy = a[0]; r8 = {a[7], a[7:1]}; end
                    default: begin cy = a[0]; r8 = {1'b0, a[7:1]}; end
                endcase
                // Only the accumulator rotate forms may have Z forced clear.
                acc_rotate = (q.kind == ebalu_pkg::K_RLC) || (q.kind == ebalu_pkg::K_RL) ||
                             (q.kind == ebalu_pkg::K_RRC) || (q.kind == ebalu_pkg::K_RR);
                f[ebalu_pkg::FLAG_C] = cy;
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00) && !(q.clear_zero && acc_rotate);
                p.result    = {8'h00, r8};
                p.flags_out = f;
            end
            ebalu_pkg::K_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00);
                p.result    = {8'h00, r8};
                p.flags_out = f;
            end
            ebalu_pkg::K_BIT: begin
                f[ebalu_pkg::FLAG_C] = cin;
                f[ebalu_pkg::FLAG_H] = 1'b1;
                f[ebalu_pkg::FLAG_Z] = ~a[q.bit_index];
                p.flags_out = f;
            end
            ebalu_pkg::K_RES: begin
                r8[q.bit_index] = 1'b0;
                p.result = {8'h00, r8};
            end
            ebalu_pkg::K_SET: begin
                r8[q.bit_index] = 1'b1;
                p.result = {8'h00, r8};
            end
            ebalu_pkg::K_DAA: begin
                f[ebalu_pkg::FLAG_N] = q.flags_in[ebalu_pkg::FLAG_N];
                f[ebalu_pkg::FLAG_C] = cin;
                if (!q.flags_in[ebalu_pkg::FLAG_N]) begin
                    if (cin || r8 > ebalu_pkg::DAA_HI_MAX) begin
                        r8 = r8 + ebalu_pkg::DAA_HI_ADJ;
                        f[ebalu_pkg::FLAG_C] = 1'b1;
                    end
                    if (q.flags_in[ebalu_pkg::FLAG_H] || r8[3:0] > ebalu_pkg::DAA_LO_MAX) begin
                        r8 = r8 + ebalu_pkg::DAA_LO_ADJ;
                    end
                end else begin
                    if (cin) begin
                        r8 = r8 - ebalu_pkg::DAA_HI_ADJ;
                    end
                    if (q.flags_in[ebalu_pkg::FLAG_H]) begin
                        r8 = r8 - ebalu_pkg::DAA_LO_ADJ;
                    end
                end
                f[ebalu_pkg::FLAG_Z] = (r8 == 8'h00);
                p.result    = {8'h00, r8};
                p.flags_out = f;
            end
            ebalu_pkg::K_CPL: begin
                p.result = {8'h00, ~a};
                p.flags_out[ebalu_pkg::FLAG_N] = 1'b1;
                p.flags_out[ebalu_pkg::FLAG_H] = 1'b1;
            end
            ebalu_pkg::K_CCF, ebalu_pkg::K_SCF: begin
                f[ebalu_pkg::FLAG_Z] = q.flags_in[ebalu_pkg::FLAG_Z];
                f[ebalu_pkg::FLAG_C] = (q.kind == ebalu_pkg::K_SCF) ? 1'b1 : ~cin;
                p.flags_out = f;
            end
            ebalu_pkg::K_ADD16: begin
                s17 = {1'b0, q.operand_a} + {1'b0, q.operand_b};
                s13 = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
                f[ebalu_pkg::FLAG_Z] = q.flags_in[ebalu_pkg::FLAG_Z];
                f[ebalu_pkg::FLAG_C] = s17[16];
                f[ebalu_pkg::FLAG_H] = s13[12];
                p.result    = s17[15:0];
                p.flags_out = f;
            end
            ebalu_pkg::K_ADD16S: begin
                // Flags come from the unsigned low-byte add; the sum uses the signed offset.
                s9 = {1'b0, a} + {1'b0, b};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                f[ebalu_pkg::FLAG_C] = s9[8];
                f[ebalu_pkg::FLAG_H] = s5[4];
                p.result    = q.operand_a + {{8{b[7]}}, b};
                p.flags_out = f;
            end
            default: begin
                // Unused codes pass operand_a and the flags through.
            end
        endcase
        return p;
    endfunction

    // Queue one request for the driver.
    task automatic queue_op(ebalu_pkg::t_kind k, logic [15:0] opa, logic [15:0] opb,
                            logic [3:0] fl, logic [2:0] bi, logic cz);
        t_alu_req q;
        q.kind       = k;
        q.operand_a  = opa;
        q.operand_b  = opb;
        q.flags_in   = fl;
        q.bit_index  = bi;
        q.clear_zero = cz;
        pending_ops = {pending_ops, q};
    endtask

    // Pick an operand, leaning toward the corners where carries and zero flags live.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {8'($urandom_range(255)), 8'hFF};
            3:       return {8'($urandom_range(255)), 8'($urandom_range(1) ? 8'h80 : 8'h7F)};
            4:       return {8'($urandom_range(255)), 4'($urandom_range(15)), 4'hF};
            default: return 16'($urandom);
        endcase
    endfunction

    // Idle pattern follows the number of requests taken: no idling, sender gaps,
    // receiver stalls, then both, repeating every 1024 requests.
    function automatic int unsigned send_idle_pct(int unsigned taken);
        case ((taken >> 8) & 3)
            1:       return 53;
            3:       return 20;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct(int unsigned taken);
        case ((taken >> 8) & 3)
            2:       return 53;
            3:       return 20;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the next pending request; predict on each accept.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.kind       <= ebalu_pkg::K_ADD;
            req_if.operand_a  <= '0;
            req_if.operand_b  <= '0;
            req_if.flags_in   <= '0;
            req_if.bit_index  <= '0;
            req_if.clear_zero <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            // The held request was taken at this edge: record what it must return.
            if (req_if.valid) begin
                expected_alu = {expected_alu, predict_alu(offered_op)};
                n_taken <= n_taken + 1;
            end
            // Advance to the next request, or leave i_req idle.
            if (pending_ops.size() != 0 &&
                $urandom_range(99) >= send_idle_pct(n_taken)) begin
                offered_op = pending_ops[0];
                pending_ops.delete(0);
                req_if.kind          <= offered_op.kind;
                req_if.operand_a     <= offered_op.operand_a;
                req_if.operand_b     <= offered_op.operand_b;
                req_if.flags_in      <= offered_op.flags_in;
                req_if.bit_index     <= offered_op.bit_index;
                req_if.clear_zero    <= offered_op.clear_zero;
                req_if.valid         <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the response side at random and check each response.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alu_rsp want;
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct(n_taken));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_alu.size() == 0) begin
                $error("unexpected response: result=%h flags_out=%h",
                       rsp_if.result, rsp_if.flags_out);
                n_errors++;
            end else begin
                want = expected_alu[0];
                expected_alu.delete(0);
                if (rsp_if.result !== want.result) begin
                    $error("result mismatch: expected %h, actual %h",
                           want.result, rsp_if.result);
                    n_errors++;
                end
                if (rsp_if.flags_out !== want.flags_out) begin
                    $error("flags_out mismatch: expected %b, actual %b",
                           want.flags_out, rsp_if.flags_out);
                    n_errors++;
                end
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_eight_bit_cpu_alu_with_flags_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        ebalu_pkg::t_kind k;

        // Directed: every operation at least once, at the corners that set each flag.
        queue_op(ebalu_pkg::K_ADD,    16'hFFFF, 16'hFF01, 4'b0000, 3'd0, 1'b0); // wraps to zero
        queue_op(ebalu_pkg::K_ADC,    16'h000F, 16'h0000, 4'b0001, 3'd0, 1'b0); // carry in gives H
        queue_op(ebalu_pkg::K_SUB,    16'h0000, 16'h0001, 4'b0000, 3'd0, 1'b0); // full borrow
        queue_op(ebalu_pkg::K_SBC,    16'h0010, 16'h000F, 4'b0001, 3'd0, 1'b0); // half borrow
        queue_op(ebalu_pkg::K_AND,    16'hFFFF, 16'h0000, 4'b1111, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_XOR,    16'h00FF, 16'hFFFF, 4'b0000, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_OR,     16'h0000, 16'h0000, 4'b1111, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_CP,     16'hAB3C, 16'h003C, 4'b0000, 3'd0, 1'b0); // a unchanged
        queue_op(ebalu_pkg::K_INC,    16'h12FF, 16'h0000, 4'b0001, 3'd0, 1'b0); // carry kept
        queue_op(ebalu_pkg::K_DEC,    16'h0001, 16'h0000, 4'b1110, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_RLC,    16'h0080, 16'h0000, 4'b0000, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_RL,     16'h0080, 16'h0000, 4'b0000, 3'd0, 1'b1); // Z forced clear
        queue_op(ebalu_pkg::K_RRC,    16'h0000, 16'h0000, 4'b1111, 3'd0, 1'b1);
        queue_op(ebalu_pkg::K_RR,     16'h0001, 16'h0000, 4'b0000, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_SLA,    16'h0080, 16'h0000, 4'b0000, 3'd0, 1'b1); // option ignored
        queue_op(ebalu_pkg::K_SRA,    16'h0081, 16'h0000, 4'b0000, 3'd0, 1'b0); // bit 7 kept
        queue_op(ebalu_pkg::K_SRL,    16'hFF01, 16'h0000, 4'b1111, 3'd0, 1'b1);
        queue_op(ebalu_pkg::K_SWAP,   16'h00F0, 16'h0000, 4'b1111, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_BIT,    16'h007F, 16'h0000, 4'b0101, 3'd7, 1'b0);
        queue_op(ebalu_pkg::K_RES,    16'hFFFF, 16'h0000, 4'b1010, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_SET,    16'h0000, 16'h0000, 4'b0101, 3'd7, 1'b0);
        queue_op(ebalu_pkg::K_DAA,    16'h009A, 16'h0000, 4'b0000, 3'd0, 1'b0); // add to zero
        queue_op(ebalu_pkg::K_DAA,    16'h0000, 16'h0000, 4'b0111, 3'd0, 1'b0); // after subtract
        queue_op(ebalu_pkg::K_CPL,    16'h1200, 16'h0000, 4'b0000, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_CCF,    16'hBEEF, 16'h0000, 4'b1111, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_SCF,    16'h0000, 16'h0000, 4'b0110, 3'd0, 1'b0);
        queue_op(ebalu_pkg::K_ADD16,  16'hFFFF, 16'h0001, 4'b1000, 3'd0, 1'b0); // bits 11 and 15
        queue_op(ebalu_pkg::K_ADD16S, 16'h00FF, 16'hFF80, 4'b1111, 3'd0, 1'b0); // negative offset
        queue_op(ebalu_pkg::t_kind'(5'd31), 16'hFFFF, 16'hFFFF, 4'b1111, 3'd7, 1'b1); // unused

        // Random: mostly defined operations, a few unused codes.
        repeat (N_RANDOM) begin
            if ($urandom_range(99) < 5) begin
                k = ebalu_pkg::t_kind'($urandom_range(31, int'(ebalu_pkg::K_ADD16S) + 1));
            end else begin
                k = ebalu_pkg::t_kind'($urandom_range(int'(ebalu_pkg::K_ADD16S)));
            end
            queue_op(k, pick_operand(), pick_operand(), 4'($urandom_range(15)),
                     3'($urandom_range(7)), 1'($urandom_range(1)));
        end

        // Hold reset, then release it for good.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every response to come back;
        // sample between edges so the clocked blocks have settled.
        while (pending_ops.size() != 0 || req_if.valid || expected_alu.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb_eight_bit_cpu_alu_with_flags_core OK");
        end else begin
            $display("tb_eight_bit_cpu_alu_with_flags_core NOT OK");
        end
        $finish;
    end

endmodule
